FILE: hdl/perspective_project_to_screen_top_macros.svh
// assertion macros used by the top module
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_TOP_MACROS_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define PPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// implication whose consequent is checked in the following cycle
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: hdl/pps_pkg.sv
`default_nettype none
package pps_pkg;
  localparam int FracBits = 16;
  // near plane limit, about 0.01 (655 / 2^16); w <= NearLimit is rejected
  localparam int NearLimit = (1 << FracBits) / 100;
  // quotient bits, one division cell per bit
  localparam int QBits = 32;
  localparam int DivBits = QBits;
  localparam int ClipBits = 66;
  // magnitude of w + cx or w - cy always fits here
  localparam int MagBits = ClipBits - FracBits;
  localparam int SizeBits = 16;
  // magnitude times size times 2^(F-1)
  localparam int ProdBits = MagBits + SizeBits + FracBits - 1;

  typedef enum logic [2:0] {
    REG_ROW_X_A = 3'd0, REG_ROW_X_B = 3'd1, REG_ROW_Y_A = 3'd2, REG_ROW_Y_B = 3'd3,
    REG_ROW_W_A = 3'd4, REG_ROW_W_B = 3'd5, REG_SCREEN = 3'd6, REG_MVALID = 3'd7
  } reg_idx_t;

  // one lane of the divider chain
  typedef struct packed {
    logic             ok;
    logic             neg;
    logic [63:0]      rem;   // running partial remainder, below den when ok
    logic [QBits-1:0] num;   // remaining numerator bits, msb first
    logic [QBits-1:0] quo;
    logic [63:0]      den;
  } lane_t;

  typedef struct packed {
    logic  vld;
    lane_t lx;
    lane_t ly;
  } cell_t;
endpackage
`default_nettype wire

FILE: hdl/pps_if.sv
`default_nettype none
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] world_x;
  logic [31:0] world_y;
  logic [31:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] screen_x;
  logic [31:0] screen_y;
  logic        point_valid;
  modport source (output valid, screen_x, screen_y, point_valid, input ready);
  modport sink (input valid, screen_x, screen_y, point_valid, output ready);
endinterface
`default_nettype wire

FILE: hdl/pps_cell.sv
`default_nettype none
// one restoring division step on both lanes
module pps_cell import pps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  cell_t      din,
  output cell_t      dout
);
  function automatic lane_t step(lane_t l);
    lane_t o;
    logic [64:0] r2;
    o = l;
    r2 = {l.rem, l.num[QBits-1]};
    o.num = {l.num[QBits-2:0], 1'b0};
    if (r2 >= {1'b0, l.den}) begin
      o.rem = 64'(r2 - {1'b0, l.den});
      o.quo = {l.quo[QBits-2:0], 1'b1};
    end else begin
      o.rem = r2[63:0];
      o.quo = {l.quo[QBits-2:0], 1'b0};
    end
    return o;
  endfunction

  // control
  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else if (en) dout.vld <= din.vld;
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dout.lx <= step(din.lx);
      dout.ly <= step(din.ly);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/pps_front.sv
`default_nettype none
// clip rows, near test and division setup, three register stages
module pps_front import pps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [31:0] wx,
  input  wire logic [31:0] wy,
  input  wire logic [31:0] wz,
  input  wire logic [63:0] regs [6],
  input  wire logic [31:0] screen,
  input  wire logic        mvalid,
  output cell_t            dout
);
  logic signed [63:0] p [3][3];
  logic signed [31:0] c3 [3];
  logic               v1, ok1;
  logic [15:0]        sw1, sh1;
  logic signed [ClipBits-1:0] clip [3];
  logic signed [ClipBits-1:0] nx, ny;
  logic               v2, ok2;
  logic [15:0]        sw2, sh2;
  logic signed [ClipBits-1:0] cw2, nx2, ny2;

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p[r][0] <= $signed(regs[2*r][31:0]) * $signed(wx);
        p[r][1] <= $signed(regs[2*r][63:32]) * $signed(wy);
        p[r][2] <= $signed(regs[2*r+1][31:0]) * $signed(wz);
        c3[r]   <= $signed(regs[2*r+1][63:32]);
      end
      ok1 <= mvalid && screen[31:16] != 16'd0 && screen[15:0] != 16'd0;
      sw1 <= screen[31:16];
      sh1 <= screen[15:0];
    end
  end

  // exact sum then floor
  always_comb begin
    for (int r = 0; r < 3; r++)
      clip[r] = (ClipBits'(p[r][0]) + ClipBits'(p[r][1]) + ClipBits'(p[r][2])
                 + (ClipBits'(c3[r]) <<< FracBits)) >>> FracBits;
    nx = clip[2] + clip[0];
    ny = clip[2] - clip[1];
  end

  // stage 2: clip values
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok2 <= ok1;
      sw2 <= sw1;
      sh2 <= sh1;
      cw2 <= clip[2];
      nx2 <= nx;
      ny2 <= ny;
    end
  end

  function automatic lane_t setup(input logic signed [ClipBits-1:0] n,
                                  input logic signed [ClipBits-1:0] w,
                                  input logic [SizeBits-1:0] sz, input logic okin);
    lane_t l;
    logic [ClipBits-1:0] a;
    logic [MagBits+SizeBits-1:0] scaled;
    logic [ProdBits-1:0] prod;
    l.neg = n[ClipBits-1];
    a = l.neg ? ClipBits'(-n) : ClipBits'(n);
    // numerator times size*2^(F-1); the upper part must stay below w so the
    // quotient fits in QBits
    scaled = (MagBits+SizeBits)'(a[MagBits-1:0]) * (MagBits+SizeBits)'(sz);
    prod = {scaled, {(FracBits-1){1'b0}}};
    l.ok = okin && (w > ClipBits'(NearLimit))
        && (64'(prod[ProdBits-1:QBits]) < w[63:0]);
    l.rem = 64'(prod[ProdBits-1:QBits]);
    l.num = prod[QBits-1:0];
    l.quo = '0;
    l.den = w[63:0];
    return l;
  endfunction

  // stage 3: lane setup
  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else if (en) dout.vld <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dout.lx <= setup(nx2, cw2, sw2, ok2);
      dout.ly <= setup(ny2, cw2, sh2, ok2);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/perspective_project_to_screen_top.sv
//  channel | direction | payload
//  pin     | in        | world_x, world_y, world_z
//  pout    | out       | screen_x, screen_y, point_valid
//  cfg     | in        | cfg_we, cfg_idx, cfg_data
// one point per cycle while the output is not stalled; 36 register stages: 3 front
// stages, one division cell per quotient bit (32) and the output register
// rst clears all valid flags and the configuration registers
// a stall at the output holds the whole chain
`default_nettype none
`include "perspective_project_to_screen_top_macros.svh"
module perspective_project_to_screen_top import pps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_data,
  pps_in_if.sink           pin,
  pps_out_if.source        pout
);
  logic [63:0] regs [6];
  logic [31:0] screen;
  logic        mvalid;
  logic        en;
  cell_t       chain [DivBits+1];
  logic [31:0] ox, oy;
  logic        ook;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) regs[i] <= '0;
      screen <= '0;
      mvalid <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_SCREEN: screen <= cfg_data[31:0];
        REG_MVALID: mvalid <= cfg_data[0];
        default:    regs[cfg_idx] <= cfg_data;
      endcase
    end
  end

  // output register frees the chain when empty or taken
  assign en = !pout.valid || pout.ready;
  assign pin.ready = en;

  pps_front u_front (
    .clk, .rst, .en, .in_vld(pin.valid && pin.ready),
    .wx(pin.world_x), .wy(pin.world_y), .wz(pin.world_z),
    .regs, .screen, .mvalid, .dout(chain[0])
  );

  for (genvar g = 0; g < DivBits; g++) begin : g_cell
    pps_cell u_cell (.clk, .rst, .en, .din(chain[g]), .dout(chain[g+1]));
  end

  // range check and sign
  always_comb begin
    ox = chain[DivBits].lx.neg ? -chain[DivBits].lx.quo : chain[DivBits].lx.quo;
    oy = chain[DivBits].ly.neg ? -chain[DivBits].ly.quo : chain[DivBits].ly.quo;
    ook = chain[DivBits].lx.ok && chain[DivBits].ly.ok
        && (chain[DivBits].lx.neg ? chain[DivBits].lx.quo <= 32'h8000_0000
                                  : chain[DivBits].lx.quo <= 32'h7FFF_FFFF)
        && (chain[DivBits].ly.neg ? chain[DivBits].ly.quo <= 32'h8000_0000
                                  : chain[DivBits].ly.quo <= 32'h7FFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) pout.valid <= 1'b0;
    else if (en) pout.valid <= chain[DivBits].vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pout.point_valid <= ook;
      pout.screen_x <= ook ? ox : 32'd0;
      pout.screen_y <= ook ? oy : 32'd0;
    end
  end

  `PPS_ASSERT_IMP(a_ready, pout.valid && !pout.ready, !pin.ready)
  `PPS_ASSERT_IMP(a_zero, pout.valid && !pout.point_valid, pout.screen_x == 32'd0)
  `PPS_ASSERT_NEXT(a_hold, pout.valid && !pout.ready, pout.valid)
endmodule
`default_nettype wire

FILE: test/tb_perspective_project_to_screen_top.sv
`default_nettype none
module tb_perspective_project_to_screen_top;
  import pps_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [63:0] cfg_data = '0;

  pps_in_if  pin ();
  pps_out_if pout ();

  perspective_project_to_screen_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .pin(pin.sink), .pout(pout.source)
  );

  localparam int Latency = 3 + DivBits + 1;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        ok;
  } screen_pt_t;

  // shadow copy of the block's registers
  logic [63:0] mat_regs [6];
  logic [31:0] screen_reg;
  logic        mvalid_reg;

  screen_pt_t expected_pts [$];
  int   errors = 0;
  longint cycles = 0;
  logic sender_idle = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    pin.valid = 1'b0;
    pin.world_x = '0;
    pin.world_y = '0;
    pin.world_z = '0;
    pout.ready = 1'b0;
    for (int i = 0; i < 6; i++) mat_regs[i] = '0;
    screen_reg = '0;
    mvalid_reg = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // floor of a 64 bit signed value by s bits
  function automatic longint floor_sh(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clip_value(input int row, input longint x, input longint y,
                                        input longint z);
    logic [63:0] a, b;
    longint c0, c1, c2, c3, p0, p1, p2, hi, lo;
    a = mat_regs[2*row];
    b = mat_regs[2*row+1];
    c0 = longint'($signed(a[31:0]));
    c1 = longint'($signed(a[63:32]));
    c2 = longint'($signed(b[31:0]));
    c3 = longint'($signed(b[63:32]));
    p0 = c0 * x;
    p1 = c1 * y;
    p2 = c2 * z;
    hi = floor_sh(p0, 2) + floor_sh(p1, 2) + floor_sh(p2, 2);
    lo = (p0 & 3) + (p1 & 3) + (p2 & 3);
    hi += c3 * (longint'(1) << (FracBits - 2));
    hi += lo >>> 2;
    return floor_sh(hi, FracBits - 2);
  endfunction

  // trunc(m * num / w) into 32 bits; returns 0 on overflow
  function automatic bit scaled_coord(input longint num, input longint w,
                                      input longint unsigned m, output logic [31:0] res);
    bit neg;
    longint unsigned a, q, r, mag, lim, quo, rem;
    neg = num < 0;
    a = neg ? longint'(-num) : num;
    q = a / longint'(w);
    r = a % longint'(w);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    res = '0;
    if (q >= 64'h1_0000_0000) return 1'b0;
    mag = m * q;
    if (mag > lim) return 1'b0;
    quo = 0;
    rem = 0;
    for (int bitn = 40; bitn >= 0; bitn--) begin
      quo = quo << 1;
      rem = rem << 1;
      if (m[bitn]) rem += r;
      while (rem >= longint'(w)) begin
        rem -= w;
        quo++;
      end
    end
    mag += quo;
    if (mag > lim) return 1'b0;
    res = neg ? 32'(-mag) : mag[31:0];
    return 1'b1;
  endfunction

  function automatic screen_pt_t project_point(input logic [31:0] wx, input logic [31:0] wy,
                                               input logic [31:0] wz);
    screen_pt_t pt;
    longint x, y, z, cx, cy, cw;
    longint unsigned wpix, hpix;
    logic [31:0] sx, sy;
    pt = '0;
    x = longint'($signed(wx));
    y = longint'($signed(wy));
    z = longint'($signed(wz));
    wpix = screen_reg[31:16];
    hpix = screen_reg[15:0];
    if (!mvalid_reg || wpix == 0 || hpix == 0) return pt;
    cx = clip_value(0, x, y, z);
    cy = clip_value(1, x, y, z);
    cw = clip_value(2, x, y, z);
    if (cw <= NearLimit) return pt;
    if (!scaled_coord(cw + cx, cw, wpix << (FracBits - 1), sx)) return pt;
    if (!scaled_coord(cw - cy, cw, hpix << (FracBits - 1), sy)) return pt;
    pt.sx = sx;
    pt.sy = sy;
    pt.ok = 1'b1;
    return pt;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    screen_pt_t want;
    if (!rst && pout.valid && pout.ready) begin
      if (expected_pts.size() == 0) begin
        report("unexpected transfer", pout.screen_x, 32'h0);
      end else begin
        want = expected_pts.pop_front();
        if (pout.screen_x !== want.sx) report("screen_x", pout.screen_x, want.sx);
        if (pout.screen_y !== want.sy) report("screen_y", pout.screen_y, want.sy);
        if (pout.point_valid !== want.ok)
          report("point_valid", 32'(pout.point_valid), 32'(want.ok));
      end
    end
  end

  // receiver stall pattern: phases of full speed and random stalls
  always @(negedge clk) begin
    int phase;
    phase = (cycles / 300) % 3;
    if (rst) pout.ready <= 1'b0;
    else if (phase == 0) pout.ready <= 1'b1;
    else if (phase == 1) pout.ready <= ($urandom_range(3, 0) != 0);
    else pout.ready <= ($urandom_range(2, 0) == 0);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SCREEN) screen_reg = val[31:0];
    else if (idx == REG_MVALID) mvalid_reg = val[0];
    else mat_regs[idx] = val;
  endtask

  // send one point, waits for its transfer
  task automatic send_point(input logic [31:0] wx, input logic [31:0] wy,
                            input logic [31:0] wz);
    pin.valid <= 1'b1;
    pin.world_x <= wx;
    pin.world_y <= wy;
    pin.world_z <= wz;
    do @(posedge clk); while (!pin.ready);
    expected_pts.push_back(project_point(wx, wy, wz));
    @(negedge clk);
    if (sender_idle) begin
      pin.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic gap(input int n);
    pin.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    pin.valid <= 1'b0;
    while (expected_pts.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [63:0] pack_pair(input int a, input int b);
    return {32'(b), 32'(a)};
  endfunction

  // simple camera: cx = scale_q * x, cy = scale_q * y, w = z
  task automatic load_camera(input int scale_q, input logic [31:0] size);
    write_reg(REG_ROW_X_A, pack_pair(scale_q, 0));
    write_reg(REG_ROW_X_B, pack_pair(0, 0));
    write_reg(REG_ROW_Y_A, pack_pair(0, scale_q));
    write_reg(REG_ROW_Y_B, pack_pair(0, 0));
    write_reg(REG_ROW_W_A, pack_pair(0, 0));
    write_reg(REG_ROW_W_B, pack_pair(32'h0001_0000, 0));
    write_reg(REG_SCREEN, {32'h0, size});
    write_reg(REG_MVALID, 64'h1);
  endtask

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(16'hFFFF, 0)) - 32'sh8000) <<< 4;
      default: return 32'($urandom_range(32'h0040_0000, 32'h0000_0100));
    endcase
  endfunction

  task automatic test_reset_rejects;
    // matrix not valid after reset
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_directed;
    sender_idle = 1'b1;
    load_camera(32'h0001_0000, {16'd640, 16'd480});
    send_point(32'h0, 32'h0, 32'h0001_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
    send_point(32'h0000_8000, 32'h0000_4000, 32'h0000_0290);  // just above near limit
    send_point(32'h0000_8000, 32'h0000_4000, 32'h0000_028F);  // on the near limit
    send_point(32'h0, 32'h0, 32'h0);                          // w of zero
    send_point(32'h0, 32'h0, 32'hFFFF_0000);                  // behind camera
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);  // overflow
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    drain();
    // extreme screen sizes, a zero width or height and a cleared matrix valid
    write_reg(REG_SCREEN, {32'h0, 16'hFFFF, 16'hFFFF});
    send_point(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
    drain();
    write_reg(REG_SCREEN, {32'h0, 16'h0000, 16'd480});
    send_point(32'h0, 32'h0, 32'h0001_0000);
    drain();
    write_reg(REG_SCREEN, {32'h0, 16'd640, 16'h0000});
    send_point(32'h0, 32'h0, 32'h0001_0000);
    drain();
    write_reg(REG_SCREEN, {32'h0, 16'd1, 16'd1});
    send_point(32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
    drain();
    write_reg(REG_MVALID, 64'h0);
    send_point(32'h0, 32'h0, 32'h0001_0000);
    drain();
    sender_idle = 1'b0;
  endtask

  // random matrices or cameras with random points, bursts and gaps
  task automatic test_random_bursts;
    int sent, burst, mode;
    sent = 0;
    while (sent < 1200) begin
      if (sent % 200 == 0) begin
        if ((sent / 200) % 3 == 2) begin
          for (int r = 0; r < 6; r++)
            write_reg(reg_idx_t'(r), {$urandom(), $urandom()});
          write_reg(REG_SCREEN, {32'h0, $urandom()});
          write_reg(REG_MVALID, 64'($urandom_range(1, 0)));
        end else begin
          load_camera(32'($urandom_range(32'h0004_0000, 32'h0000_4000)),
                      {16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1))});
          write_reg(REG_ROW_W_A, pack_pair($urandom_range(255, 0), $urandom_range(255, 0)));
        end
      end
      burst = $urandom_range(20, 1);
      for (int i = 0; i < burst && sent < 1200; i++) begin
        mode = $urandom_range(2, 0);
        send_point(rand_word(mode == 0 ? 0 : 1), rand_word(mode == 0 ? 0 : 1),
                   mode == 0 ? rand_word(0) : rand_word(2));
        sent++;
        if (sent % 200 == 0) break;
      end
      if (sent % 200 == 0) drain();
      else if ($urandom_range(3, 0) != 0) gap($urandom_range(6, 1));
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_rejects();
    test_directed();
    test_random_bursts();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/pps_pkg.sv
hdl/pps_if.sv
hdl/pps_cell.sv
hdl/pps_front.sv
hdl/perspective_project_to_screen_top.sv
test/tb_perspective_project_to_screen_top.sv
